// ===== design/sal_pkg.sv =====
package sal_pkg;

  localparam int SLOTS      = 32;
  localparam int DATA_WIDTH = 32;
  localparam int ID_W       = $clog2(SLOTS);
  localparam int CNT_W      = $clog2(SLOTS + 1);

  // command codes
  localparam logic [2:0] CMD_ADD      = 3'd0;
  localparam logic [2:0] CMD_ADD_ZERO = 3'd1;
  localparam logic [2:0] CMD_REMOVE   = 3'd2;
  localparam logic [2:0] CMD_READ     = 3'd3;
  localparam logic [2:0] CMD_LIST     = 3'd4;

  // status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_BAD  = 2'd2;

  localparam logic [CNT_W-1:0] NO_SLOT = CNT_W'(SLOTS);

  typedef struct packed {
    logic [2:0]            command;
    logic [ID_W-1:0]       slot_or_position;
    logic [DATA_WIDTH-1:0] write_data;
  } req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [CNT_W-1:0]      result_slot;
    logic [DATA_WIDTH-1:0] read_data;
    logic [CNT_W-1:0]      live_count;
  } rsp_t;

  // broadcast control for the live-list cells
  typedef struct packed {
    logic            append;
    logic            remove;
    logic [ID_W-1:0] sel;
    logic [ID_W-1:0] new_id;
  } cell_ctrl_t;

endpackage

// ===== design/sal_ram.sv =====
module sal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/sal_cell.sv =====
// One live-list entry. On remove, every cell at or after the matching one
// takes its right neighbor's entry; on append, the first empty cell loads.
module sal_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  sal_pkg::cell_ctrl_t          ctrl,
  input  logic                         prev_valid,
  input  logic                         hit_in,
  input  logic [sal_pkg::ID_W-1:0]     next_id,
  input  logic                         next_valid,
  output logic [sal_pkg::ID_W-1:0]     id,
  output logic                         valid,
  output logic                         hit_out
);

  logic shift_en;
  logic load_en;

  assign hit_out  = hit_in | (valid && (id == ctrl.sel));
  assign shift_en = ctrl.remove && hit_out;
  assign load_en  = ctrl.append && !valid && prev_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift_en) begin
      valid <= next_valid;
    end else if (load_en) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      id <= next_id;
    end else if (load_en) begin
      id <= ctrl.new_id;
    end
  end

endmodule

// ===== design/slot_allocator_with_live_list.sv =====
// A transferred command is captured and the FSM enters execute; the result
//   and done are registered at its end. Busy is high in the execute state,
//   so no new command is taken until the last one has executed; execute
//   covers the registered data RAM read and the list update.
// Reset (rst, synchronous): pool empty, live count zero, no result pending.
// The receiver cannot stall: each result is shown for exactly one cycle.
module slot_allocator_with_live_list (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  sal_pkg::req_t   request,
  output logic            done,
  output sal_pkg::rsp_t   result
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // captured command
  logic [2:0]                     cmd_q;
  logic [sal_pkg::ID_W-1:0]       sel_q;
  logic [sal_pkg::DATA_WIDTH-1:0] data_q;

  // pool state
  logic [sal_pkg::SLOTS-1:0] occupied;
  logic [sal_pkg::SLOTS-1:0] occupied_next;
  logic [sal_pkg::CNT_W-1:0] count;
  logic [sal_pkg::CNT_W-1:0] count_next;

  sal_pkg::rsp_t rsp_next;

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state == S_EXEC);

  // Data store: read address goes out in the transfer cycle so the word is
  // ready in the execute cycle. Writes land at the end of execute.
  logic                           ram_we;
  logic [sal_pkg::DATA_WIDTH-1:0] ram_wdata;
  logic [sal_pkg::DATA_WIDTH-1:0] ram_rdata;
  logic [sal_pkg::ID_W-1:0]       free_id;
  logic                           free_found;

  sal_ram #(
    .WIDTH (sal_pkg::DATA_WIDTH),
    .DEPTH (sal_pkg::SLOTS)
  ) u_data (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_id),
    .wdata (ram_wdata),
    .raddr (request.slot_or_position),
    .rdata (ram_rdata)
  );

  // Live list: a row of cells, oldest id in cell 0. The hit chain runs left
  // to right; cells at or right of the match shift left on remove.
  sal_pkg::cell_ctrl_t      ctrl;
  logic [sal_pkg::ID_W-1:0] cell_id    [sal_pkg::SLOTS];
  logic [sal_pkg::SLOTS-1:0] cell_valid;
  logic [sal_pkg::SLOTS:0]  hit;
  logic                     found;

  assign hit[0] = 1'b0;
  assign found  = hit[sal_pkg::SLOTS];

  for (genvar i = 0; i < sal_pkg::SLOTS; i++) begin : g_cell
    logic                     pv;
    logic [sal_pkg::ID_W-1:0] nid;
    logic                     nv;

    if (i == 0) begin : g_first
      assign pv = 1'b1;
    end else begin : g_mid
      assign pv = cell_valid[i-1];
    end

    if (i == sal_pkg::SLOTS - 1) begin : g_last
      assign nid = '0;
      assign nv  = 1'b0;
    end else begin : g_inner
      assign nid = cell_id[i+1];
      assign nv  = cell_valid[i+1];
    end

    sal_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .prev_valid (pv),
      .hit_in     (hit[i]),
      .next_id    (nid),
      .next_valid (nv),
      .id         (cell_id[i]),
      .valid      (cell_valid[i]),
      .hit_out    (hit[i+1])
    );
  end

  // Lowest free slot; scanning down lets the lowest index win.
  always_comb begin
    free_id    = '0;
    free_found = 1'b0;
    for (int s = sal_pkg::SLOTS - 1; s >= 0; s--) begin
      if (!occupied[s]) begin
        free_id    = sal_pkg::ID_W'(s);
        free_found = 1'b1;
      end
    end
  end

  // Execute-cycle decode
  always_comb begin
    state_next           = state;
    ram_we               = 1'b0;
    ram_wdata            = data_q;
    ctrl                 = '0;
    ctrl.sel             = sel_q;
    ctrl.new_id          = free_id;
    occupied_next        = occupied;
    count_next           = count;
    rsp_next.status      = sal_pkg::STAT_BAD;
    rsp_next.result_slot = sal_pkg::NO_SLOT;
    rsp_next.read_data   = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
        case (cmd_q)
          sal_pkg::CMD_ADD, sal_pkg::CMD_ADD_ZERO: begin
            if (free_found) begin
              ram_we                 = 1'b1;
              ram_wdata              = (cmd_q == sal_pkg::CMD_ADD) ? data_q : '0;
              occupied_next[free_id] = 1'b1;
              ctrl.append            = 1'b1;
              count_next             = count + 1'b1;
              rsp_next.status        = sal_pkg::STAT_OK;
              rsp_next.result_slot   = {1'b0, free_id};
            end else begin
              rsp_next.status = sal_pkg::STAT_FULL;
            end
          end
          sal_pkg::CMD_REMOVE: begin
            if (found) begin
              ctrl.remove          = 1'b1;
              occupied_next[sel_q] = 1'b0;
              count_next           = count - 1'b1;
              rsp_next.status      = sal_pkg::STAT_OK;
            end
          end
          sal_pkg::CMD_READ: begin
            if (occupied[sel_q]) begin
              rsp_next.status    = sal_pkg::STAT_OK;
              rsp_next.read_data = ram_rdata;
            end
          end
          sal_pkg::CMD_LIST: begin
            if ({1'b0, sel_q} < count) begin
              rsp_next.status      = sal_pkg::STAT_OK;
              rsp_next.result_slot = {1'b0, cell_id[sel_q]};
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    rsp_next.live_count = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      occupied <= '0;
      count    <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      occupied <= occupied_next;
      count    <= count_next;
      done     <= (state == S_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= request.command;
      sel_q  <= request.slot_or_position;
      data_q <= request.write_data;
    end
    if (state == S_EXEC) begin
      result <= rsp_next;
    end
  end

  // occupied bits and the live count must agree
  a_count_matches_map: assert property (@(posedge clk) disable iff (rst)
    $countones(occupied) == count)
    else $error("live count disagrees with occupied map");

  // the number of valid list cells must equal the live count
  a_cells_match_count: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == count)
    else $error("live list cells disagree with live count");

  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_EXEC))
    else $error("result strobe without an execute cycle");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && !done)
    else $error("transfer not followed by execute cycle");

  a_full_means_full: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == sal_pkg::STAT_FULL) |->
      result.live_count == sal_pkg::NO_SLOT)
    else $error("pool full reported below capacity");

endmodule

// ===== verif/slot_allocator_with_live_list_tb.sv =====
module slot_allocator_with_live_list_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sal_pkg::*;

  // Watchdog: ~1300 commands plus their pauses stay well under this.
  localparam int CYCLE_LIMIT = 100000;
  localparam int RANDOM_ITEMS = 1250;
  // Past this many random commands the sender stops idling.
  localparam int CALM_AFTER = 1100;

  typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_e;

  typedef struct {
    req_t cause;
    rsp_t reply;
  } pending_reply_t;

  // Pool shadow plus the queue of replies still owed by the block.
  class slot_scoreboard;
    logic [DATA_WIDTH-1:0] stored_word [SLOTS];
    bit                    taken [SLOTS];
    logic [ID_W-1:0]       order [SLOTS];
    int                    live;
    pending_reply_t        replies_due [$];
    int                    mismatches;

    function new();
      foreach (taken[s]) begin
        taken[s]       = 1'b0;
        stored_word[s] = '0;
        order[s]       = '0;
      end
      live       = 0;
      mismatches = 0;
    endfunction

    // Applies one command to the shadow pool and returns the reply it owes.
    function rsp_t execute_command(req_t r);
      rsp_t            rsp;
      int              free_slot;
      int              spot;
      logic [ID_W-1:0] id;
      rsp             = '0;
      rsp.status      = STAT_BAD;
      rsp.result_slot = NO_SLOT;
      id              = r.slot_or_position;
      case (r.command)
        CMD_ADD, CMD_ADD_ZERO: begin
          free_slot = SLOTS;
          for (int s = SLOTS - 1; s >= 0; s--)
            if (!taken[s]) free_slot = s;
          if (free_slot == SLOTS) begin
            rsp.status = STAT_FULL;
          end else begin
            stored_word[free_slot] = (r.command == CMD_ADD) ? r.write_data : '0;
            taken[free_slot]       = 1'b1;
            order[live]            = free_slot[ID_W-1:0];
            live++;
            rsp.status      = STAT_OK;
            rsp.result_slot = CNT_W'(free_slot);
          end
        end
        CMD_REMOVE: begin
          spot = -1;
          for (int i = 0; i < live; i++)
            if (spot < 0 && order[i] == id) spot = i;
          if (spot >= 0) begin
            for (int i = spot; i < live - 1; i++)
              order[i] = order[i + 1];
            live--;
            taken[id]  = 1'b0;
            rsp.status = STAT_OK;
          end
        end
        CMD_READ: begin
          if (taken[id]) begin
            rsp.status    = STAT_OK;
            rsp.read_data = stored_word[id];
          end
        end
        CMD_LIST: begin
          if (int'(id) < live) begin
            rsp.status      = STAT_OK;
            rsp.result_slot = CNT_W'(order[id]);
          end
        end
        default: ;
      endcase
      rsp.live_count = CNT_W'(live);
      return rsp;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    function void note_request(req_t r);
      pending_reply_t p;
      p.cause = r;
      p.reply = execute_command(r);
      replies_due.push_back(p);
    endfunction

    task check_result(rsp_t got);
      pending_reply_t p;
      if (replies_due.size() == 0) begin
        report("reply strobed with no command outstanding");
        return;
      end
      p = replies_due.pop_front();
      if (got.status !== p.reply.status)
        report($sformatf("cmd %0d sel %0d: status %0d, want %0d", p.cause.command,
                         p.cause.slot_or_position, got.status, p.reply.status));
      if (got.result_slot !== p.reply.result_slot)
        report($sformatf("cmd %0d sel %0d: result_slot %0d, want %0d", p.cause.command,
                         p.cause.slot_or_position, got.result_slot, p.reply.result_slot));
      if (got.read_data !== p.reply.read_data)
        report($sformatf("cmd %0d sel %0d: read_data %h, want %h", p.cause.command,
                         p.cause.slot_or_position, got.read_data, p.reply.read_data));
      if (got.live_count !== p.reply.live_count)
        report($sformatf("cmd %0d sel %0d: live_count %0d, want %0d", p.cause.command,
                         p.cause.slot_or_position, got.live_count, p.reply.live_count));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  req_t request = '0;
  rsp_t result;

  slot_scoreboard sb = new();
  int cycle_count = 0;
  int issued = 0;

  slot_allocator_with_live_list u_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Reply side: the strobe lasts one cycle and cannot be held off, so every
  // edge with done high is a completed transfer.
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  function automatic req_t mk(logic [2:0] cmd, int sel, logic [DATA_WIDTH-1:0] data);
    req_t r;
    r.command          = cmd;
    r.slot_or_position = ID_W'(sel);
    r.write_data       = data;
    return r;
  endfunction

  // Holds the command on the port until an edge sees start high with busy low;
  // that edge is the transfer. start stays high on return so that a follow-on
  // command can go out back to back.
  task automatic send(req_t item);
    request <= item;
    start   <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_request(item);
    issued++;
  endtask

  task automatic pause(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic logic [DATA_WIDTH-1:0] pick_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // A live id most of the time, so removes and reads mostly hit.
  function automatic int pick_slot();
    if (sb.live > 0 && $urandom_range(9) != 0)
      return sb.order[$urandom_range(sb.live - 1)];
    return $urandom_range(SLOTS - 1);
  endfunction

  // Random command, biased by the traffic mode so that the pool swings
  // between empty and full.
  function automatic req_t pick_item(traffic_mode_e mode);
    req_t r;
    int   c;
    int   add_cut;
    int   rem_cut;
    r.command          = CMD_READ;
    r.slot_or_position = ID_W'($urandom_range(SLOTS - 1));
    r.write_data       = pick_word();
    c       = $urandom_range(99);
    add_cut = (mode == MODE_FILL) ? 60 : (mode == MODE_DRAIN) ? 10 : 32;
    rem_cut = add_cut + ((mode == MODE_DRAIN) ? 55 : (mode == MODE_FILL) ? 10 : 28);
    if (c < add_cut) begin
      r.command = $urandom_range(1) ? CMD_ADD : CMD_ADD_ZERO;
    end else if (c < rem_cut) begin
      r.command          = CMD_REMOVE;
      r.slot_or_position = ID_W'(pick_slot());
    end else if (c < 97) begin
      if ($urandom_range(1)) begin
        r.command          = CMD_READ;
        r.slot_or_position = ID_W'(pick_slot());
      end else begin
        r.command = CMD_LIST;
        // mostly valid positions, sometimes at or past the live count
        if (sb.live > 0 && $urandom_range(4) != 0)
          r.slot_or_position = ID_W'($urandom_range(sb.live - 1));
      end
    end else begin
      r.command = 3'($urandom_range(7, 5));
    end
    return r;
  endfunction

  task automatic fill_pool();
    while (sb.live < SLOTS)
      send(mk($urandom_range(1) ? CMD_ADD : CMD_ADD_ZERO, $urandom_range(SLOTS - 1),
              pick_word()));
    // two more adds must both report full
    send(mk(CMD_ADD, $urandom_range(SLOTS - 1), pick_word()));
    send(mk(CMD_ADD_ZERO, $urandom_range(SLOTS - 1), pick_word()));
  endtask

  task automatic drain_pool();
    while (sb.live > 0)
      send(mk(CMD_REMOVE, sb.order[$urandom_range(sb.live - 1)], pick_word()));
    send(mk(CMD_REMOVE, $urandom_range(SLOTS - 1), pick_word()));
    send(mk(CMD_LIST, 0, pick_word()));
  endtask

  initial begin
    traffic_mode_e mode;
    int            span;
    bit            idle_ok;
    int            guard;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // ---- directed: empty pool, data extremes, list shift, bad commands ----
    send(mk(CMD_READ, 0, '0));                 // read of a free slot
    send(mk(CMD_LIST, 0, '0));                 // position past an empty list
    send(mk(CMD_REMOVE, 7, '1));               // unknown id
    send(mk(CMD_ADD, 31, '1));                 // all-ones word -> slot 0
    send(mk(CMD_ADD_ZERO, 0, 32'hDEAD_BEEF));  // data ignored -> slot 1
    pause(3);
    send(mk(CMD_ADD, 0, '0));                  // slot 2
    send(mk(CMD_ADD, 15, 32'hA5A5_A5A5));      // slot 3
    send(mk(CMD_READ, 0, '0));
    send(mk(CMD_READ, 1, '1));
    send(mk(CMD_READ, 31, '0));                // highest id, free
    send(mk(CMD_LIST, 2, '0));
    send(mk(CMD_LIST, 4, '0));                 // position equal to count
    send(mk(CMD_LIST, 31, '0));
    send(mk(CMD_REMOVE, 1, '0));               // middle of the list: later ids shift
    pause(1);
    send(mk(CMD_LIST, 1, '0));
    send(mk(CMD_READ, 1, '0));                 // freed slot
    send(mk(CMD_REMOVE, 1, '0));               // already removed
    send(mk(CMD_ADD, 0, 32'h1234_5678));       // reuses slot 1, goes to the tail
    send(mk(CMD_LIST, 3, '0));
    send(mk(3'd5, 0, '0));                     // unused command codes
    send(mk(3'd6, 31, '1));
    send(mk(3'd7, 16, '0));
    send(mk(CMD_REMOVE, 0, '0));               // head of the list
    send(mk(CMD_LIST, 0, '0));
    issued = 0;

    // ---- random: full fill first, then mode-biased episodes ----
    fill_pool();
    while (issued < RANDOM_ITEMS) begin
      case ($urandom_range(2))
        0:       mode = MODE_FILL;
        1:       mode = MODE_DRAIN;
        default: mode = MODE_MIXED;
      endcase
      span    = $urandom_range(20, 80);
      idle_ok = ($urandom_range(2) != 0);
      if (issued > RANDOM_ITEMS / 2 && issued < RANDOM_ITEMS / 2 + 80) begin
        drain_pool();
        fill_pool();
      end
      repeat (span) begin
        if (idle_ok && issued < CALM_AFTER && $urandom_range(4) == 0)
          pause($urandom_range(1, 8));
        send(pick_item(mode));
      end
    end
    start <= 1'b0;

    // ---- wind down: collect outstanding replies, allow the pipeline to settle ----
    guard = 0;
    while (sb.replies_due.size() != 0 && guard < 64) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
    if (sb.replies_due.size() != 0)
      sb.report($sformatf("%0d replies never arrived", sb.replies_due.size()));

    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
